// ===== rtl/ctd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunked transfer decoder package
// Shared constants, codes and the queue item type of the decoder.
// ---------------------------------------------------------------------------
package ctd_pkg;

	// Width of the chunk size / data byte counter
	localparam int COUNT_BITS = 32;

	// Queue between classifier and decoder core
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIZE,
		PH_EXT,
		PH_DATA,
		PH_TRAIL,
		PH_DONE,
		PH_BAD
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_ZERO,
		ST_EARLY,
		ST_BAD
	} status_t;

	// One classified body beat
	typedef struct packed {
		logic [7:0] body_byte;
		logic       body_end;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} ctd_item_t;

endpackage

// ===== rtl/ctd_ifs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunked transfer decoder channels
// Valid/ready channels for raw body beats and decoded result beats.
// ---------------------------------------------------------------------------
interface ctd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       body_end;

	modport source (output valid, output body_byte, output body_end, input ready);
	modport sink (input valid, input body_byte, input body_end, output ready);
endinterface

interface ctd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       has_payload;
	logic [1:0] finish_status;

	modport source (output valid, output payload_byte, output has_payload,
		output finish_status, input ready);
	modport sink (input valid, input payload_byte, input has_payload,
		input finish_status, output ready);
endinterface

// ===== rtl/ctd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunked transfer decoder front end
// Accepts body beats, classifies each byte (hex digit, CR, LF) and
// hands the classified beat on through a one-stage register.
// ---------------------------------------------------------------------------
module ctd_front (
	input  logic              clk,
	input  logic              arst_n,
	ctd_in_if.sink            in_ch,
	output ctd_pkg::ctd_item_t item,
	output logic              item_valid,
	input  logic              item_ready
);

	logic               vld_s1;
	ctd_pkg::ctd_item_t item_s1;
	ctd_pkg::ctd_item_t cls;
	logic               take;

	// Classify the incoming byte
	always_comb begin
		cls           = '0;
		cls.body_byte = in_ch.body_byte;
		cls.body_end  = in_ch.body_end;
		cls.is_cr     = (in_ch.body_byte == ctd_pkg::CH_CR);
		cls.is_lf     = (in_ch.body_byte == ctd_pkg::CH_LF);
		if (in_ch.body_byte >= 8'h30 && in_ch.body_byte <= 8'h39) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = in_ch.body_byte[3:0];
		end else if ((in_ch.body_byte >= 8'h41 && in_ch.body_byte <= 8'h46) ||
				(in_ch.body_byte >= 8'h61 && in_ch.body_byte <= 8'h66)) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = in_ch.body_byte[3:0] + 4'd9;
		end
	end

	assign in_ch.ready = !vld_s1 || item_ready;
	assign take        = in_ch.valid && in_ch.ready;

	// Stage register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (item_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	// Stage register payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= cls;
		end
	end

	assign item       = item_s1;
	assign item_valid = vld_s1;

endmodule

// ===== rtl/ctd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunked transfer decoder queue
// Short FIFO of classified beats between the front end and the core.
// ---------------------------------------------------------------------------
module ctd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  ctd_pkg::ctd_item_t wr_item,
	input  logic               wr_valid,
	output logic               wr_ready,
	output ctd_pkg::ctd_item_t rd_item,
	output logic               rd_valid,
	input  logic               rd_ready
);

	ctd_pkg::ctd_item_t             mem [ctd_pkg::QUEUE_DEPTH];
	logic [ctd_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [ctd_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [ctd_pkg::QUEUE_CW-1:0]   count_q;
	logic                           push;
	logic                           pop;

	assign wr_ready = (count_q != ctd_pkg::QUEUE_CW'(ctd_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_item  = mem[rd_ptr_q];

	// Write storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ctd_pkg::QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ctd_pkg::QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ctd_pkg::QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ctd_pkg::QUEUE_CW'(1);
			end
		end
	end

endmodule

// ===== rtl/ctd_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chunked transfer decoder core
// Runs the chunk parsing state machine on classified beats and loads
// data bytes and finish reports into the output register.
// ---------------------------------------------------------------------------
module ctd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  ctd_pkg::ctd_item_t item,
	input  logic               item_valid,
	output logic               item_ready,
	ctd_out_if.source          out_ch
);

	localparam int CB = ctd_pkg::COUNT_BITS;

	ctd_pkg::phase_t  phase_q, phase_d;
	logic [CB-1:0]    remain_q, remain_d;
	logic [3:0]       digits_q, digits_d;
	logic             saw_cr_q, saw_cr_d;
	logic [1:0]       trail_q, trail_d;
	logic             fin_q, fin_d;

	logic             out_vld_q;
	logic [7:0]       pay_q;
	logic             has_q;
	ctd_pkg::status_t st_q;

	logic             emit;
	logic             has_d;
	ctd_pkg::status_t st_d;
	logic             do_size;
	logic             do_tail;
	logic             pop;

	assign item_ready = !out_vld_q || out_ch.ready;
	assign pop        = item_valid && item_ready;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ctd_pkg::PH_START;
			remain_q <= '0;
			digits_q <= '0;
			saw_cr_q <= 1'b0;
			trail_q  <= '0;
			fin_q    <= 1'b0;
		end else if (pop) begin
			phase_q  <= phase_d;
			remain_q <= remain_d;
			digits_q <= digits_d;
			saw_cr_q <= saw_cr_d;
			trail_q  <= trail_d;
			fin_q    <= fin_d;
		end
	end

	// Next state and result for one beat
	always_comb begin
		phase_d  = phase_q;
		remain_d = remain_q;
		digits_d = digits_q;
		saw_cr_d = saw_cr_q;
		trail_d  = trail_q;
		fin_d    = fin_q;
		emit     = 1'b0;
		has_d    = 1'b0;
		st_d     = ctd_pkg::ST_RUN;
		do_size  = 1'b0;
		do_tail  = 1'b0;

		case (phase_q)
			ctd_pkg::PH_START: begin
				if (!item.is_hex) begin
					phase_d = ctd_pkg::PH_BAD;
					st_d    = ctd_pkg::ST_BAD;
				end else begin
					phase_d = ctd_pkg::PH_SIZE;
					do_size = 1'b1;
				end
			end
			ctd_pkg::PH_SIZE: begin
				do_size = 1'b1;
			end
			ctd_pkg::PH_EXT: begin
				do_tail = 1'b1;
			end
			ctd_pkg::PH_DATA: begin
				emit     = 1'b1;
				has_d    = 1'b1;
				remain_d = remain_q - CB'(1);
				if (remain_d == '0) begin
					phase_d = ctd_pkg::PH_TRAIL;
					trail_d = 2'd2;
				end
			end
			ctd_pkg::PH_TRAIL: begin
				trail_d = trail_q - 2'd1;
				if (trail_d == 2'd0) begin
					phase_d  = ctd_pkg::PH_SIZE;
					digits_d = '0;
					saw_cr_d = 1'b0;
				end
			end
			default: begin
			end
		endcase

		// Accumulate a size digit, flag an oversized size as bad, or leave the size for the line tail
		if (do_size) begin
			if (!item.is_hex) begin
				phase_d = ctd_pkg::PH_EXT;
				do_tail = 1'b1;
			end else if (remain_q[CB-1 -: 4] != 4'd0) begin
				phase_d = ctd_pkg::PH_BAD;
				st_d    = ctd_pkg::ST_BAD;
			end else begin
				remain_d = {remain_q[CB-5:0], item.hex_val};
				if (digits_q != 4'hF) begin
					digits_d = digits_q + 4'd1;
				end
			end
		end

		// Look for CR LF closing the size line
		if (do_tail) begin
			if (saw_cr_q && item.is_lf) begin
				saw_cr_d = 1'b0;
				digits_d = '0;
				if (remain_q == '0) begin
					phase_d = ctd_pkg::PH_DONE;
					st_d    = ctd_pkg::ST_ZERO;
				end else begin
					phase_d = ctd_pkg::PH_DATA;
				end
			end else begin
				saw_cr_d = item.is_cr;
			end
		end

		if (st_d != ctd_pkg::ST_RUN) begin
			emit  = 1'b1;
			fin_d = 1'b1;
		end

		// Report how the body ended on its last beat
		if (item.body_end && !fin_d) begin
			if (phase_d == ctd_pkg::PH_DATA || phase_d == ctd_pkg::PH_TRAIL) begin
				st_d = ctd_pkg::ST_EARLY;
			end else if (phase_d == ctd_pkg::PH_SIZE && digits_d == 4'd0) begin
				st_d = ctd_pkg::ST_EARLY;
			end else begin
				st_d = ctd_pkg::ST_BAD;
			end
			emit = 1'b1;
		end

		// Drop back to start of body after the last beat
		if (item.body_end) begin
			phase_d  = ctd_pkg::PH_START;
			remain_d = '0;
			digits_d = '0;
			saw_cr_d = 1'b0;
			trail_d  = '0;
			fin_d    = 1'b0;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pop && emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			pay_q <= has_d ? item.body_byte : 8'd0;
			has_q <= has_d;
			st_q  <= st_d;
		end
	end

	assign out_ch.valid         = out_vld_q;
	assign out_ch.payload_byte  = pay_q;
	assign out_ch.has_payload   = has_q;
	assign out_ch.finish_status = st_q;

	// A finished or malformed body has already been reported
	a_fin_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ctd_pkg::PH_DONE || phase_q == ctd_pkg::PH_BAD) |-> fin_q)
		else $error("finish phase without finish report");

	// Data phase always has bytes left
	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ctd_pkg::PH_DATA) |-> (remain_q != '0))
		else $error("data phase with zero count");

	// Trailer phase always has bytes to drop
	a_trail_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ctd_pkg::PH_TRAIL) |-> (trail_q != 2'd0))
		else $error("trailer phase with zero skip count");

	// A data result carries only running or ended-early status
	a_data_st: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && has_q) |-> (st_q == ctd_pkg::ST_RUN || st_q == ctd_pkg::ST_EARLY))
		else $error("data beat with bad status");

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
`timescale 1ns / 1ps
// Path: a body beat passes the classifier register, the queue and the
// output register before it is offered as a result beat. When out_ch is
// ready, one body beat per cycle passes; the core parses one byte per cycle.
// Reset: arst_n clears the parser to start of body and empties the queue and
// output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Chunked transfer decoder
// Decodes a chunked HTTP body into payload bytes and a finish status.
// ---------------------------------------------------------------------------
module chunked_transfer_decoder (
	input  logic      clk,
	input  logic      arst_n,
	ctd_in_if.sink    in_ch,
	ctd_out_if.source out_ch
);

	ctd_pkg::ctd_item_t fr_item;
	logic               fr_valid;
	logic               fr_ready;
	ctd_pkg::ctd_item_t q_item;
	logic               q_valid;
	logic               q_ready;

	ctd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.item       (fr_item),
		.item_valid (fr_valid),
		.item_ready (fr_ready)
	);

	ctd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (fr_item),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.rd_item  (q_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	ctd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.out_ch     (out_ch)
	);

endmodule
